// ===== rtl/pdsw_pkg.sv =====
// ----------------------------------------------------------------------------
// pdsw_pkg
// Shared constants, types and helpers for the 4:1 weighted pixel downscaler.
// ----------------------------------------------------------------------------
package pdsw_pkg;

    localparam int OUT_WIDTH_DEF  = 40;
    localparam int OUT_HEIGHT_DEF = 36;

    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int PITCH_W = 13;
    localparam int LP_W    = 12;
    localparam int BAND_W  = 10;
    localparam int XMAX_W  = 10;
    localparam int HS_W    = 12;
    localparam int VS_W    = 16;
    localparam int WT_W    = 3;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd160;
    localparam logic [PITCH_W-1:0] PITCH_MAX   = 13'd4096;

    typedef logic [1:0] phase_t;

    typedef struct packed {
        logic              wr;
        logic              emit;
        logic              row_end;
        logic              frame_end;
        phase_t            phase;
        logic [XMAX_W-1:0] x;
        logic [3*HS_W-1:0] hsum;
    } col_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
    } out_beat_t;

    function automatic logic [WT_W-1:0] tap_weight(input phase_t p);
        logic [WT_W-1:0] w;
        case (p)
            2'd0:    w = 3'd3;
            2'd1:    w = 3'd5;
            2'd2:    w = 3'd5;
            2'd3:    w = 3'd3;
            default: w = 3'd3;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pdsw_front.sv =====
// ----------------------------------------------------------------------------
// pdsw_front
// Raster position tracking and horizontal weighted block sums; issues one
// column-store update per completed block segment.
// ----------------------------------------------------------------------------
module pdsw_front
    #(
        parameter int OUT_WIDTH  = pdsw_pkg::OUT_WIDTH_DEF,
        parameter int OUT_HEIGHT = pdsw_pkg::OUT_HEIGHT_DEF
    )
    (
        input  logic                          clk,
        input  logic                          rst_n,
        input  logic                          accept,
        input  logic [pdsw_pkg::PIX_W-1:0]    pixel,
        input  logic                          frame_start,
        input  logic [pdsw_pkg::PITCH_W-1:0]  pitch,
        output pdsw_pkg::col_req_t            req
    );
    import pdsw_pkg::*;

    logic [LP_W-1:0]   lp_reg, lp_next;
    phase_t            phase_reg, phase_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              done_reg, done_next;
    logic [3*HS_W-1:0] hsum_reg, hsum_next;

    logic [LP_W-1:0]    lp0;
    phase_t             ph0;
    logic [BAND_W-1:0]  band0;
    logic               done0;
    logic [3*HS_W-1:0]  hsum0;
    logic [3*HS_W-1:0]  hsum_add;
    logic               active;
    logic               blk_end;
    logic [WT_W-1:0]    wh;
    logic [PITCH_W-1:0] lp_inc;
    logic [BAND_W:0]    band_inc;
    logic [XMAX_W-1:0]  x;
    logic               re;

    always_comb
    begin
        lp0   = frame_start ? '0 : lp_reg;
        ph0   = frame_start ? '0 : phase_reg;
        band0 = frame_start ? '0 : band_reg;
        done0 = frame_start ? 1'b0 : done_reg;
        hsum0 = frame_start ? '0 : hsum_reg;

        active = !done0 && ({1'b0, band0} < (BAND_W+1)'(OUT_HEIGHT))
                 && ({1'b0, lp0} < PITCH_W'(4 * OUT_WIDTH));
        wh = tap_weight(lp0[1:0]);
        for (int c = 0; c < 3; c++)
        begin
            hsum_add[c*HS_W +: HS_W] = HS_W'(hsum0[c*HS_W +: HS_W]
                + HS_W'(wh) * HS_W'(pixel[c*CH_W +: CH_W]));
        end
        blk_end = active && (lp0[1:0] == 2'd3);
        x       = lp0[LP_W-1:2];
        re      = (x == XMAX_W'(OUT_WIDTH - 1));

        req.wr        = accept && blk_end;
        req.emit      = (ph0 == 2'd3);
        req.row_end   = re;
        req.frame_end = re && ({1'b0, band0} == (BAND_W+1)'(OUT_HEIGHT - 1));
        req.phase     = ph0;
        req.x         = x;
        req.hsum      = hsum_add;

        lp_inc   = {1'b0, lp0} + 1'b1;
        band_inc = {1'b0, band0} + 1'b1;

        lp_next    = lp_inc[LP_W-1:0];
        phase_next = ph0;
        band_next  = band0;
        done_next  = done0;
        if (blk_end)
            hsum_next = '0;
        else if (active)
            hsum_next = hsum_add;
        else
            hsum_next = hsum0;

        if (lp_inc >= pitch)
        begin
            lp_next   = '0;
            hsum_next = '0;
            if (!done0)
            begin
                phase_next = ph0 + 2'd1;
                if (ph0 == 2'd3)
                begin
                    if (band_inc >= (BAND_W+1)'(OUT_HEIGHT))
                        done_next = 1'b1;
                    else
                        band_next = band_inc[BAND_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg    <= '0;
            phase_reg <= '0;
            band_reg  <= '0;
            done_reg  <= 1'b0;
            hsum_reg  <= '0;
        end
        else if (accept)
        begin
            lp_reg    <= lp_next;
            phase_reg <= phase_next;
            band_reg  <= band_next;
            done_reg  <= done_next;
            hsum_reg  <= hsum_next;
        end
    end

endmodule

// ===== rtl/pdsw_colmem.sv =====
// ----------------------------------------------------------------------------
// pdsw_colmem
// Column accumulator store: synchronous read, vertical weighted add, write
// back in the cycle after the read.
// ----------------------------------------------------------------------------
module pdsw_colmem
    #(
        parameter int OUT_WIDTH = pdsw_pkg::OUT_WIDTH_DEF
    )
    (
        input  logic                   clk,
        input  logic                   rst_n,
        input  pdsw_pkg::col_req_t     req,
        output logic                   push,
        output pdsw_pkg::out_beat_t    push_beat,
        output logic                   emit_pending
    );
    import pdsw_pkg::*;

    localparam int X_W = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;

    // Same-entry updates are at least one block (four beats) apart, so the
    // write-back always lands before the next read of that entry.
    logic [3*VS_W-1:0] mem [OUT_WIDTH];

    logic              s1_valid_reg;
    col_req_t          s1_reg;
    logic [3*VS_W-1:0] rd_reg;
    logic [3*VS_W-1:0] vsum;
    logic [WT_W-1:0]   wv;
    logic [VS_W-1:0]   base;

    always_comb
    begin
        wv = tap_weight(s1_reg.phase);
        for (int c = 0; c < 3; c++)
        begin
            base = (s1_reg.phase == 2'd0) ? '0 : rd_reg[c*VS_W +: VS_W];
            vsum[c*VS_W +: VS_W] = VS_W'(base
                + VS_W'(wv) * VS_W'(s1_reg.hsum[c*HS_W +: HS_W]));
        end
        for (int c = 0; c < 3; c++)
        begin
            push_beat.pixel[c*CH_W +: CH_W] = vsum[c*VS_W + 8 +: CH_W];
        end
        push_beat.row_end   = s1_reg.row_end;
        push_beat.frame_end = s1_reg.frame_end;
        push         = s1_valid_reg && s1_reg.emit;
        emit_pending = push;
    end

    always_ff @(posedge clk)
    begin
        if (req.wr)
            rd_reg <= mem[req.x[X_W-1:0]];
        if (s1_valid_reg)
            mem[s1_reg.x[X_W-1:0]] <= vsum;
    end

    always_ff @(posedge clk)
    begin
        if (req.wr)
            s1_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= req.wr;
    end

endmodule

// ===== rtl/pdsw_outq.sv =====
// ----------------------------------------------------------------------------
// pdsw_outq
// Two-entry result queue decoupling the output handshake from the pipeline.
// ----------------------------------------------------------------------------
module pdsw_outq
    (
        input  logic                 clk,
        input  logic                 rst_n,
        input  logic                 push,
        input  pdsw_pkg::out_beat_t  push_beat,
        input  logic                 pop,
        output logic                 not_empty,
        output pdsw_pkg::out_beat_t  head,
        output logic [1:0]           count
    );
    import pdsw_pkg::*;

    out_beat_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != 2'd0);
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
        not_empty   = (count_reg != 2'd0);
        head        = q_reg[rd_ptr_reg];
        count       = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/pixel_downscale_4x_weighted_core.sv =====
// ----------------------------------------------------------------------------
// pixel_downscale_4x_weighted_core
// 4:1 weighted (3,5,5,3) RGB image downscaler with a column accumulator store.
//
//   channel | dir | signals                        | beat contents
//   s_      | in  | tvalid tready tdata tuser      | source pixel, frame start
//   m_      | out | tvalid tready tdata tlast tuser| scaled pixel, row/frame end
//   cfg_    | in  | valid ready data               | line pitch (13 bits)
//
// One source pixel per clock unless stalled. The column store is read at
// the edge that accepts the beat completing a block; the vertical add and
// write-back take the next cycle, and an emitted result enters the output
// queue at that write-back edge. Input stalls only when the two-entry
// result queue may not hold another result. The column store (OUT_WIDTH x
// 48 bits) is not cleared at reset; each band's first line writes it.
// Config writes are taken every cycle; pitch 0 acts as 1, above 4096 as 4096.
// ----------------------------------------------------------------------------
module pixel_downscale_4x_weighted_core
    #(
        parameter int OUT_WIDTH  = pdsw_pkg::OUT_WIDTH_DEF,
        parameter int OUT_HEIGHT = pdsw_pkg::OUT_HEIGHT_DEF
    )
    (
        input  logic                          clk,
        input  logic                          rst_n,
        input  logic                          s_tvalid,
        output logic                          s_tready,
        input  logic [23:0]                   s_tdata,  // pixel_in[23:0]
        input  logic                          s_tuser,  // frame_start
        output logic                          m_tvalid,
        input  logic                          m_tready,
        output logic [23:0]                   m_tdata,  // pixel_out[23:0]
        output logic                          m_tlast,  // row_end
        output logic                          m_tuser,  // frame_end
        input  logic                          cfg_valid,
        output logic                          cfg_ready,
        input  logic [pdsw_pkg::PITCH_W-1:0]  cfg_data
    );
    import pdsw_pkg::*;

    logic [PITCH_W-1:0] pitch_reg, pitch_next;
    logic               accept;
    col_req_t           req;
    logic               push;
    out_beat_t          push_beat;
    logic               emit_pending;
    logic               q_not_empty;
    out_beat_t          q_head;
    logic [1:0]         q_count;

    always_comb
    begin
        if (cfg_data == '0)
            pitch_next = PITCH_W'(1);
        else if (cfg_data > PITCH_MAX)
            pitch_next = PITCH_MAX;
        else
            pitch_next = cfg_data;
        cfg_ready = 1'b1;
        s_tready  = ({1'b0, q_count} + {2'b00, emit_pending}) < 3'd2;
        accept    = s_tvalid && s_tready;
        m_tvalid  = q_not_empty;
        m_tdata   = q_head.pixel;
        m_tlast   = q_head.row_end;
        m_tuser   = q_head.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pitch_reg <= PITCH_RESET;
        else if (cfg_valid && cfg_ready)
            pitch_reg <= pitch_next;
    end

    pdsw_front
        #(
            .OUT_WIDTH  (OUT_WIDTH),
            .OUT_HEIGHT (OUT_HEIGHT)
        )
        u_front
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .accept      (accept),
            .pixel       (s_tdata),
            .frame_start (s_tuser),
            .pitch       (pitch_reg),
            .req         (req)
        );

    pdsw_colmem
        #(
            .OUT_WIDTH (OUT_WIDTH)
        )
        u_colmem
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .req          (req),
            .push         (push),
            .push_beat    (push_beat),
            .emit_pending (emit_pending)
        );

    pdsw_outq u_outq
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .push      (push),
            .push_beat (push_beat),
            .pop       (m_tready),
            .not_empty (q_not_empty),
            .head      (q_head),
            .count     (q_count)
        );

endmodule
